FILE: src/wid_pkg.sv
// Shared constants, types and the width mask helper function of the wide integer divider.
package wid_pkg;

	localparam int MAX_BITS   = 256;
	localparam int LIMB_BITS  = 64;
	localparam int LIMB_SHIFT = 6;
	localparam int LIMBS      = MAX_BITS / LIMB_BITS;
	localparam int LIMB_IDX_W = (LIMBS > 1) ? $clog2(LIMBS) : 1;
	localparam int NL_W       = $clog2(LIMBS + 1);
	localparam int W_BITS     = $clog2(MAX_BITS + 1);
	localparam int STEP_W     = $clog2(MAX_BITS);
	localparam int CFG_W      = 9;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_MASK,
		ST_NEG,
		ST_DIV,
		ST_FIX,
		ST_EXT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                  load;
		logic                  mask;
		logic                  neg;
		logic                  step;
		logic                  fix;
		logic                  ext;
		logic [LIMB_IDX_W-1:0] limb;
		logic [STEP_W-1:0]     bit_idx;
		logic [W_BITS-1:0]     width;
	} dp_cmd_t;

	typedef struct packed {
		logic den_zero;
	} dp_stat_t;

	// Ones in the bit positions below the operand width.
	function automatic logic [MAX_BITS-1:0] width_mask(input logic [W_BITS-1:0] w);
		logic [MAX_BITS-1:0] m;
		for (int i = 0; i < MAX_BITS; i++) begin
			m[i] = (W_BITS'(i) < w);
		end
		return m;
	endfunction

endpackage

FILE: src/wide_integer_divider.sv
// Top level of the wide integer divider: sequencer and datapath with stream ports.
//
//  channel  dir  beat content
//  cfg      in   cfg_wdata: operand width in bits, taken when cfg_wen is high
//  s        in   tdata: dividend limb, divisor limb; tuser: unsigned_div, want_quotient
//  m        out  tdata: result limb; tlast: last limb; tuser: divide_by_zero
//
// One operation takes nl input beats, where nl is the width in 64-bit limbs, then
// the mask, negate, divide, fix and extend states (the single restoring subtract
// step runs once per quotient bit), then nl output beats; a zero divisor skips the subtract loop.
// The input is not ready while an operation is being worked on or delivered.
// Reset clears the sequencer and sets the width to its maximum.
module wide_integer_divider (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [8:0]   cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // dividend_limb [63:0], divisor_limb [127:64]
	input  logic [1:0]   s_tuser,   // unsigned_div [0], want_quotient [1]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // result_limb [63:0]
	output logic         m_tlast,
	output logic [0:0]   m_tuser    // divide_by_zero [0]
);
	import wid_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     dz;

	wid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tlast   (m_tlast),
		.stat      (stat),
		.cmd       (cmd)
	);

	wid_dp u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.in_data  (s_tdata),
		.in_mode  (s_tuser),
		.stat     (stat),
		.out_limb (m_tdata),
		.out_dz   (dz)
	);

	assign m_tuser = dz;

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result beat is offered");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("result beat offered after the last limb");

	a_flag_steady: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && $past(m_tvalid) |-> $stable(m_tuser))
		else $error("divide by zero flag changed within one result");
`endif

endmodule

FILE: src/wid_ctrl.sv
// Sequencer of the divider: state machine, limb and step counters, width register.
module wid_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [8:0]        cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic              m_tlast,
	input  wid_pkg::dp_stat_t stat,
	output wid_pkg::dp_cmd_t  cmd
);
	import wid_pkg::*;

	state_t                state_q, state_d;
	logic [LIMB_IDX_W-1:0] limb_q;
	logic [STEP_W-1:0]     step_q;
	logic [W_BITS-1:0]     width_q;
	logic [W_BITS-1:0]     eff_width;
	logic [W_BITS:0]       nl_sum;
	logic [NL_W-1:0]       nl;
	logic                  last_limb;
	logic                  s_acc;
	logic                  m_acc;

	always_comb begin
		if (cfg_wdata == '0) begin
			eff_width = W_BITS'(1);
		end else if (32'(cfg_wdata) > MAX_BITS) begin
			eff_width = W_BITS'(MAX_BITS);
		end else begin
			eff_width = W_BITS'(cfg_wdata);
		end
	end

	assign nl_sum    = {1'b0, width_q} + (W_BITS + 1)'(LIMB_BITS - 1);
	assign nl        = NL_W'(nl_sum >> LIMB_SHIFT);
	assign last_limb = (NL_W'(limb_q) == nl - NL_W'(1));
	assign s_acc     = s_tvalid && s_tready;
	assign m_acc     = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limb_q  <= '0;
			step_q  <= '0;
			width_q <= W_BITS'(MAX_BITS);
		end else if (cfg_wen) begin
			width_q <= eff_width;
			limb_q  <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						limb_q <= last_limb ? '0 : limb_q + LIMB_IDX_W'(1);
					end
				end
				ST_NEG: begin
					step_q <= STEP_W'(width_q - W_BITS'(1));
				end
				ST_DIV: begin
					step_q <= step_q - STEP_W'(1);
				end
				ST_OUT: begin
					if (m_acc) begin
						limb_q <= last_limb ? '0 : limb_q + LIMB_IDX_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		if (cfg_wen) begin
			state_d = ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (s_acc && last_limb) begin
						state_d = ST_MASK;
					end
				end
				ST_MASK: state_d = ST_NEG;
				ST_NEG: begin
					state_d = stat.den_zero ? ST_FIX : ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_d = ST_FIX;
					end
				end
				ST_FIX: state_d = ST_EXT;
				ST_EXT: state_d = ST_OUT;
				ST_OUT: begin
					if (m_acc && last_limb) begin
						state_d = ST_LOAD;
					end
				end
				default: state_d = ST_LOAD;
			endcase
		end
	end

	always_comb begin
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		m_tlast     = 1'b0;
		cmd         = '0;
		cmd.limb    = limb_q;
		cmd.bit_idx = step_q;
		cmd.width   = width_q;
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_MASK: cmd.mask = 1'b1;
			ST_NEG:  cmd.neg  = 1'b1;
			ST_DIV:  cmd.step = 1'b1;
			ST_FIX:  cmd.fix  = 1'b1;
			ST_EXT:  cmd.ext  = 1'b1;
			ST_OUT: begin
				m_tvalid = 1'b1;
				m_tlast  = last_limb;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: src/wid_dp.sv
// Datapath of the divider: operand registers, restoring subtract step and result fix-up.
module wid_dp (
	input  logic                              clk,
	input  wid_pkg::dp_cmd_t                  cmd,
	input  logic [2*wid_pkg::LIMB_BITS-1:0]   in_data,
	input  logic [1:0]                        in_mode,
	output wid_pkg::dp_stat_t                 stat,
	output logic [wid_pkg::LIMB_BITS-1:0]     out_limb,
	output logic                              out_dz
);
	import wid_pkg::*;

	logic [MAX_BITS-1:0] num_q, den_q, quo_q, res_q;
	logic [MAX_BITS:0]   rem_q;
	logic                uns_q, wantq_q, sgn_num_q, sgn_den_q, dz_q;

	logic [MAX_BITS-1:0] mask;
	logic [STEP_W-1:0]   top_idx;
	logic                sgn_num, sgn_den;
	logic [MAX_BITS:0]   r_shift;
	logic [MAX_BITS+1:0] sub;
	logic                ge;
	logic [MAX_BITS-1:0] fix_src, fix_val;
	logic                fix_neg;

	assign mask    = width_mask(cmd.width);
	assign top_idx = STEP_W'(cmd.width - W_BITS'(1));
	assign sgn_num = !uns_q && num_q[top_idx];
	assign sgn_den = !uns_q && den_q[top_idx];
	assign stat.den_zero = (den_q == '0);

	assign r_shift = {rem_q[MAX_BITS-1:0], num_q[cmd.bit_idx]};
	assign sub     = {1'b0, r_shift} - {2'b00, den_q};
	assign ge      = !sub[MAX_BITS+1];

	always_comb begin
		fix_neg = 1'b0;
		if (dz_q) begin
			fix_src = wantq_q ? {MAX_BITS{1'b1}} : num_q;
		end else if (wantq_q) begin
			fix_src = quo_q;
			fix_neg = sgn_num_q ^ sgn_den_q;
		end else begin
			fix_src = rem_q[MAX_BITS-1:0];
			fix_neg = sgn_num_q;
		end
		fix_val = (fix_neg ? (~fix_src + MAX_BITS'(1)) : fix_src) & mask;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q[cmd.limb*LIMB_BITS +: LIMB_BITS] <= in_data[LIMB_BITS-1:0];
			den_q[cmd.limb*LIMB_BITS +: LIMB_BITS] <= in_data[2*LIMB_BITS-1:LIMB_BITS];
			uns_q   <= in_mode[0];
			wantq_q <= in_mode[1];
		end
		if (cmd.mask) begin
			num_q <= num_q & mask;
			den_q <= den_q & mask;
		end
		if (cmd.neg) begin
			// Operands turn into magnitudes; a zero divisor leaves the dividend as it was.
			sgn_num_q <= sgn_num;
			sgn_den_q <= sgn_den;
			dz_q      <= stat.den_zero;
			rem_q     <= '0;
			quo_q     <= '0;
			if (!stat.den_zero) begin
				if (sgn_num) begin
					num_q <= (~num_q + MAX_BITS'(1)) & mask;
				end
				if (sgn_den) begin
					den_q <= (~den_q + MAX_BITS'(1)) & mask;
				end
			end
		end
		if (cmd.step) begin
			rem_q <= ge ? sub[MAX_BITS:0] : r_shift;
			quo_q <= {quo_q[MAX_BITS-2:0], ge};
		end
		if (cmd.fix) begin
			res_q <= fix_val;
		end
		if (cmd.ext) begin
			if (!uns_q && res_q[top_idx]) begin
				res_q <= res_q | ~mask;
			end
		end
	end

	assign out_limb = res_q[cmd.limb*LIMB_BITS +: LIMB_BITS];
	assign out_dz   = dz_q;

endmodule

FILE: sim/wide_integer_divider_test.sv
// Self-checking testbench of the wide integer divider: directed corner cases, then random traffic.
module wide_integer_divider_test;
	import wid_pkg::*;

	localparam int SETTLE_CYCLES = MAX_BITS + 16;
	localparam int ITEM_TARGET   = 310;

	localparam logic SIGNED_OP   = 1'b0;
	localparam logic UNSIGNED_OP = 1'b1;
	localparam logic REMAINDER   = 1'b0;
	localparam logic QUOTIENT    = 1'b1;

	typedef logic [MAX_BITS-1:0] wide_t;

	typedef struct packed {
		logic [LIMB_BITS-1:0] limb;
		logic                 last;
		logic                 dz;
	} result_beat_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wen = 1'b0;
	logic [8:0]   cfg_wdata = 9'd0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;   // dividend_limb [63:0], divisor_limb [127:64]
	logic [1:0]   s_tuser = '0;   // unsigned_div [0], want_quotient [1]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;        // result_limb [63:0]
	logic         m_tlast;
	logic [0:0]   m_tuser;        // divide_by_zero [0]

	// Own copy of the divider state, advanced on every accepted input beat.
	logic [8:0]   width_reg = 9'd256;
	int           loaded_limbs = 0;
	wide_t        dividend_acc = '0;
	wide_t        divisor_acc = '0;
	result_beat_t expected_beats[$];
	result_beat_t exp_beat;

	int mismatch_count = 0;
	int items_sent = 0;
	bit fast_send = 1'b0;
	bit rx_fast = 1'b0;
	int rx_hold = 0;

	wide_integer_divider dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int eff_width(logic [8:0] w);
		if (w == 9'd0) return 1;
		if (int'(w) > MAX_BITS) return MAX_BITS;
		return int'(w);
	endfunction

	function automatic wide_t low_mask(int ew);
		if (ew >= MAX_BITS) return '1;
		return (wide_t'(1) << ew) - wide_t'(1);
	endfunction

	function automatic wide_t rand_wide();
		wide_t v;
		for (int i = 0; i < MAX_BITS / 32; i++) v[i*32 +: 32] = $urandom;
		return v;
	endfunction

	// Works out the quotient or remainder of the loaded operands and queues its limbs.
	task automatic predict_division(logic is_uns, logic want_q);
		int           ew;
		int           nl;
		wide_t        mask;
		wide_t        n;
		wide_t        d;
		wide_t        res;
		logic         sn;
		logic         sd;
		logic         dz;
		result_beat_t beat;
		ew = eff_width(width_reg);
		nl = (ew + LIMB_BITS - 1) / LIMB_BITS;
		mask = low_mask(ew);
		n = dividend_acc & mask;
		d = divisor_acc & mask;
		sn = !is_uns && n[ew-1];
		sd = !is_uns && d[ew-1];
		dz = (d == '0);
		if (dz) begin
			res = want_q ? mask : n;
		end else begin
			// Divide magnitudes; the signed minimum still fits as an unsigned magnitude.
			if (sn) n = (-n) & mask;
			if (sd) d = (-d) & mask;
			if (want_q) begin
				res = n / d;
				if (sn != sd) res = -res;
			end else begin
				res = n % d;
				if (sn) res = -res;
			end
		end
		res &= mask;
		if (!is_uns && res[ew-1]) res |= ~mask;
		for (int i = 0; i < nl; i++) begin
			beat.limb = res[i*LIMB_BITS +: LIMB_BITS];
			beat.last = (i == nl - 1);
			beat.dz = dz;
			expected_beats.push_back(beat);
		end
	endtask

	task automatic send_limb_pair(logic [63:0] dvd, logic [63:0] dvs, logic is_uns,
		logic want_q);
		int gap;
		int nl;
		gap = fast_send ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dvs, dvd};
		s_tuser <= {want_q, is_uns};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		nl = (eff_width(width_reg) + LIMB_BITS - 1) / LIMB_BITS;
		if (loaded_limbs >= nl) loaded_limbs = 0;
		dividend_acc[loaded_limbs*LIMB_BITS +: LIMB_BITS] = dvd;
		divisor_acc[loaded_limbs*LIMB_BITS +: LIMB_BITS] = dvs;
		if (loaded_limbs + 1 < nl) begin
			loaded_limbs++;
		end else begin
			loaded_limbs = 0;
			predict_division(is_uns, want_q);
		end
	endtask

	// The flags only matter on the final beat, so the earlier beats carry random ones.
	task automatic send_operation(wide_t dvd, wide_t dvs, logic is_uns, logic want_q);
		int nl;
		nl = (eff_width(width_reg) + LIMB_BITS - 1) / LIMB_BITS;
		if ($urandom_range(0, 3) == 0) fast_send = !fast_send;
		for (int i = 0; i < nl; i++) begin
			if (i == nl - 1) begin
				send_limb_pair(dvd[i*LIMB_BITS +: LIMB_BITS], dvs[i*LIMB_BITS +: LIMB_BITS],
					is_uns, want_q);
			end else begin
				send_limb_pair(dvd[i*LIMB_BITS +: LIMB_BITS], dvs[i*LIMB_BITS +: LIMB_BITS],
					1'($urandom), 1'($urandom));
			end
		end
	endtask

	task automatic wait_until_drained();
		s_tvalid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_width(logic [8:0] w);
		wait_until_drained();
		cfg_wen <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_wen <= 1'b0;
		width_reg = w;
		loaded_limbs = 0;
	endtask

	task automatic test_reset_width();
		send_operation(rand_wide(), rand_wide() >> $urandom_range(1, 200), UNSIGNED_OP, QUOTIENT);
	endtask

	task automatic test_signed_extremes();
		wide_t smin;
		wide_t smax;
		smin = wide_t'(1) << 63;
		smax = smin - wide_t'(1);
		set_width(9'd64);
		send_operation(smin, '1, SIGNED_OP, QUOTIENT);
		send_operation(smin, '1, SIGNED_OP, REMAINDER);
		send_operation('1, wide_t'(1), UNSIGNED_OP, QUOTIENT);
		send_operation('0, '1, UNSIGNED_OP, QUOTIENT);
		send_operation(-wide_t'(7), wide_t'(2), SIGNED_OP, QUOTIENT);
		send_operation(-wide_t'(7), wide_t'(2), SIGNED_OP, REMAINDER);
		send_operation(wide_t'(7), -wide_t'(2), SIGNED_OP, QUOTIENT);
		send_operation(wide_t'(7), -wide_t'(2), SIGNED_OP, REMAINDER);
		send_operation(smax, smin, SIGNED_OP, REMAINDER);
	endtask

	task automatic test_divide_by_zero();
		set_width(9'd64);
		send_operation(rand_wide(), '0, SIGNED_OP, QUOTIENT);
		send_operation(rand_wide(), '0, SIGNED_OP, REMAINDER);
		send_operation(rand_wide(), '0, UNSIGNED_OP, QUOTIENT);
		// A divisor whose only set bit lies above the width still counts as zero.
		set_width(9'd8);
		send_operation(rand_wide(), wide_t'(9'h100), UNSIGNED_OP, REMAINDER);
	endtask

	task automatic test_width_limits();
		// Zero selects a one-bit width, where minus one over minus one wraps back to minus one.
		set_width(9'd0);
		send_operation('1, '1, SIGNED_OP, QUOTIENT);
		set_width(9'd511);
		send_operation(rand_wide(), rand_wide() >> 100, SIGNED_OP, REMAINDER);
	endtask

	task automatic test_width_change_midway();
		set_width(9'd256);
		send_limb_pair(64'($urandom) << 32 | 64'($urandom), 64'($urandom), SIGNED_OP, QUOTIENT);
		set_width(9'd64);
		send_operation(rand_wide(), wide_t'(13), UNSIGNED_OP, REMAINDER);
	endtask

	task automatic test_random_operations();
		logic [8:0] w;
		int         ew;
		int         nl;
		int         ops;
		wide_t      mask;
		wide_t      dvd;
		wide_t      dvs;
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0: w = 9'($urandom_range(1, 8));
				1: w = 9'd64;
				2: w = $urandom_range(0, 1) ? 9'd63 : 9'd65;
				3: w = 9'd128;
				4: w = 9'd256;
				5: w = $urandom_range(0, 2) == 0 ? 9'd0 : 9'($urandom_range(257, 511));
				default: w = 9'($urandom_range(1, 256));
			endcase
			set_width(w);
			ew = eff_width(w);
			nl = (ew + LIMB_BITS - 1) / LIMB_BITS;
			mask = low_mask(ew);
			ops = $urandom_range(3, 10);
			repeat (ops) begin
				case ($urandom_range(0, 5))
					0: dvd = wide_t'(1) << (ew - 1);
					1: dvd = '0;
					2: dvd = '1;
					3: dvd = rand_wide() >> $urandom_range(0, MAX_BITS - 1);
					default: dvd = rand_wide();
				endcase
				if ($urandom_range(0, 1)) dvd |= rand_wide() & ~mask;
				case ($urandom_range(0, 9))
					0: dvs = '0;
					1: dvs = wide_t'(1);
					2: dvs = '1;
					3: dvs = dvd;
					4: dvs = rand_wide() & ~mask;
					5, 6: dvs = rand_wide() >> $urandom_range(0, MAX_BITS - 1);
					default: dvs = rand_wide();
				endcase
				send_operation(dvd, dvs, 1'($urandom), 1'($urandom));
			end
			// Now and then leave an operation unfinished; the next width write discards it.
			if (nl > 1 && $urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, nl - 1))
					send_limb_pair(64'(rand_wide()), 64'(rand_wide()), 1'($urandom),
						1'($urandom));
			end
		end
	endtask

	// Result side: compares each beat with the oldest expectation and stalls at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual limb %h last %b dz %b",
						$time, m_tdata, m_tlast, m_tuser[0]);
					mismatch_count++;
				end else begin
					exp_beat = expected_beats.pop_front();
					if (m_tdata !== exp_beat.limb) begin
						$display("%0t: result limb mismatch, expected %h, actual %h",
							$time, exp_beat.limb, m_tdata);
						mismatch_count++;
					end
					if (m_tlast !== exp_beat.last) begin
						$display("%0t: last limb mismatch, expected %b, actual %b",
							$time, exp_beat.last, m_tlast);
						mismatch_count++;
					end
					if (m_tuser[0] !== exp_beat.dz) begin
						$display("%0t: divide-by-zero flag mismatch, expected %b, actual %b",
							$time, exp_beat.dz, m_tuser[0]);
						mismatch_count++;
					end
				end
				rx_hold = rx_fast ? 0 : $urandom_range(0, 19);
				if ($urandom_range(0, 15) == 0) rx_fast = !rx_fast;
			end else if (rx_hold > 0) begin
				rx_hold--;
			end
			m_tready <= (rx_hold == 0);
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_width();
		test_signed_extremes();
		test_divide_by_zero();
		test_width_limits();
		test_width_change_midway();
		test_random_operations();
		wait_until_drained();
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
src/wid_pkg.sv
src/wid_ctrl.sv
src/wid_dp.sv
src/wide_integer_divider.sv
sim/wide_integer_divider_test.sv
